/* sv/ffha_pkg.sv */
// Shared types and constants of the first-fit heap allocator.
// Depends on nothing; imported by first_fit_heap_allocator_top and tb.
package ffha_pkg;

   // Heap geometry
   localparam int HEAP_UNITS = 16384;
   localparam int UNIT_BYTES = 16;
   localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
   localparam int ADDR_W     = $clog2(HEAP_UNITS);
   localparam int LEN_W      = ADDR_W + 1;
   localparam int SUM_W      = LEN_W + 1;
   localparam int BYTES_W    = 16;
   localparam int WALK_LIMIT = 4 * HEAP_UNITS + 8;
   localparam int STEP_W     = $clog2(WALK_LIMIT + 2);

   // Stream payload widths
   localparam int REQ_DATA_W = ((BYTES_W + ADDR_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 + ADDR_W + 7) / 8) * 8;

   // Configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_REQUEST = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_GROW    = 1'b1;
   localparam logic [BYTES_W-1:0]     MAX_REQUEST_RESET = 16'd10240;
   localparam logic [LEN_W-1:0]       MIN_GROW_RESET    = 15'd1024;

   // Operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TOO_LARGE = 2'd1,
      STATUS_NO_MEMORY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_A_HEAD,
      S_A_FIRST,
      S_A_EVAL,
      S_A_SPLIT,
      S_A_RESUME,
      S_A_NEXT,
      S_P_START,
      S_P_WALK,
      S_P_BPLEN,
      S_P_NXRD,
      S_P_PREV,
      S_FINISH
   } fsm_state_type;

endpackage

/* sv/first_fit_heap_allocator_top.sv */
// First-fit heap allocator: free-list sequencer around two header memories.
// Depends on ffha_pkg.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+--------------------------------------
//   req_    | in        | tvalid / tready  | tuser: operation; tdata: bytes, address
//   rsp_    | out       | tvalid / tready  | tdata: status, granted address
//   csr_    | in        | write enable     | csr_index selects register, csr_wdata
//
// One transaction is worked on at a time. An allocate walks the free list
// from the rover, one memory read per entry visited, and splits a block that
// is larger than needed; when the walk returns to the rover it grows the heap
// and links the new block in by the insertion walk, merging it with the upper
// neighbor where they touch. A free walks the list the same way and merges
// upward; an ignored free or a too-large request goes straight to finish.
// The header memories have a single read port, so each list hop is one
// memory read.
// Reset clears the control state only; the header memories are not cleared,
// the first allocate builds the sentinel entry at unit 0.
// A new request is taken only in idle; a finished result waits in the output
// register while the next request is accepted and worked on.
module first_fit_heap_allocator_top (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ffha_pkg::REQ_DATA_W-1:0]     req_tdata,  // request_bytes, block_address, pad
   input  logic                                req_tuser,  // operation
   // result
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ffha_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // status, granted_address
   // configuration
   input  logic                                csr_we,
   input  logic [ffha_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [ffha_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ffha_pkg::*;

   // Header memories: next link and block length per unit
   logic [ADDR_W-1:0] link_mem [HEAP_UNITS];
   logic [LEN_W-1:0]  len_mem  [HEAP_UNITS];

   logic [ADDR_W-1:0] raddr;
   logic [ADDR_W-1:0] lnk_q;
   logic [LEN_W-1:0]  len_q;
   logic              link_we, len_we;
   logic [ADDR_W-1:0] link_waddr, len_waddr;
   logic [ADDR_W-1:0] link_wdata;
   logic [LEN_W-1:0]  len_wdata;

   // Control state
   fsm_state_type     state_ff, state_in;
   logic [ADDR_W-1:0] rover_ff, rover_in;
   logic              ready_ff, ready_in;
   logic [LEN_W-1:0]  brk_ff, brk_in;
   logic [BYTES_W-1:0] max_bytes_ff, max_bytes_in;
   logic [LEN_W-1:0]  min_grow_ff, min_grow_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic              op_ff, op_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [LEN_W-1:0]  units_ff, units_in;
   logic [ADDR_W-1:0] prev_ff, prev_in;
   logic [ADDR_W-1:0] p_ff, p_in;
   logic [ADDR_W-1:0] nx_ff, nx_in;
   logic [ADDR_W-1:0] bp_ff, bp_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic [LEN_W-1:0]  plen_ff, plen_in;
   logic [LEN_W-1:0]  bplen_ff, bplen_in;
   logic [ADDR_W-1:0] bplink_ff, bplink_in;
   logic [STEP_W-1:0] asteps_ff, asteps_in;
   logic [STEP_W-1:0] psteps_ff, psteps_in;
   logic              grow_ff, grow_in;
   status_type        status_ff, status_in;
   logic [ADDR_W-1:0] gaddr_ff, gaddr_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Decisions
   logic              req_fire;
   logic              too_large;
   logic [BYTES_W:0]  bytes_round;
   logic [LEN_W-1:0]  units_calc;
   logic              a_fit, a_exact, a_at_rover, a_tail_bad;
   logic [LEN_W-1:0]  a_rest;
   logic [SUM_W-1:0]  a_tail_sum;
   logic [LEN_W-1:0]  grow_nu;
   logic [SUM_W-1:0]  grow_end;
   logic              grow_bad;
   logic [STEP_W-1:0] asteps_next, psteps_next;
   logic              a_over, p_over;
   logic              p_brk;
   logic              bp_merge_nx, p_merge_bp;
   logic [ADDR_W-1:0] rel_bp;
   logic              rel_skip;
   logic              out_free;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Memory ports: one write each, one shared read address, registered data
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      lnk_q <= link_mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_waddr] <= len_wdata;
      end
      len_q <= len_mem[raddr];
   end

   // Shared compares and sums
   always_comb begin
      too_large   = bytes_ff > max_bytes_ff;
      bytes_round = ({1'b0, bytes_ff} + (BYTES_W+1)'(UNIT_BYTES - 1)) >> UNIT_SHIFT;
      units_calc  = LEN_W'(bytes_round) + LEN_W'(1);

      a_fit       = len_q >= units_ff;
      a_exact     = len_q == units_ff;
      a_rest      = len_q - units_ff;
      a_tail_sum  = SUM_W'(p_ff) + SUM_W'(a_rest);
      a_tail_bad  = a_tail_sum >= SUM_W'(HEAP_UNITS);
      a_at_rover  = p_ff == rover_ff;

      grow_nu     = (units_ff < min_grow_ff) ? min_grow_ff : units_ff;
      grow_end    = SUM_W'(brk_ff) + SUM_W'(grow_nu);
      grow_bad    = grow_end > SUM_W'(HEAP_UNITS);

      asteps_next = asteps_ff + STEP_W'(1);
      psteps_next = psteps_ff + STEP_W'(1);
      a_over      = asteps_next > STEP_W'(WALK_LIMIT);
      p_over      = psteps_next > STEP_W'(WALK_LIMIT);

      // Insertion point: between p and its successor, or across the wrap
      p_brk = (bp_ff > p_ff && bp_ff < lnk_q) ||
              (p_ff >= lnk_q && (bp_ff > p_ff || bp_ff < lnk_q));

      bp_merge_nx = (SUM_W'(bp_ff) + SUM_W'(len_q)) == SUM_W'(nx_ff);
      p_merge_bp  = (SUM_W'(p_ff) + SUM_W'(plen_ff)) == SUM_W'(bp_ff);

      rel_bp   = addr_ff - ADDR_W'(1);
      rel_skip = !ready_ff || (addr_ff < ADDR_W'(2)) || (LEN_W'(rel_bp) >= brk_ff);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_START;
         end
         S_START: begin
            if (op_ff == OP_ALLOC) begin
               state_in = too_large ? S_FINISH : S_A_HEAD;
            end else begin
               state_in = rel_skip ? S_FINISH : S_P_START;
            end
         end
         S_A_HEAD:  state_in = S_A_FIRST;
         S_A_FIRST: state_in = S_A_EVAL;
         S_A_EVAL: begin
            priority if (a_fit) begin
               if (a_exact)         state_in = S_FINISH;
               else if (a_tail_bad) state_in = S_FINISH;
               else                 state_in = S_A_SPLIT;
            end else if (a_at_rover) begin
               state_in = grow_bad ? S_FINISH : S_P_START;
            end else if (a_over) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_A_EVAL;
            end
         end
         S_A_SPLIT:  state_in = S_FINISH;
         S_A_RESUME: state_in = S_A_NEXT;
         S_A_NEXT:   state_in = a_over ? S_FINISH : S_A_EVAL;
         S_P_START:  state_in = S_P_WALK;
         S_P_WALK: begin
            priority if (p_brk) state_in = S_P_BPLEN;
            else if (p_over)    state_in = S_FINISH;
            else                state_in = S_P_WALK;
         end
         S_P_BPLEN: state_in = bp_merge_nx ? S_P_NXRD : S_P_PREV;
         S_P_NXRD:  state_in = S_P_PREV;
         S_P_PREV:  state_in = grow_ff ? S_A_RESUME : S_FINISH;
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath, memory ports and register updates
   always_comb begin
      raddr       = '0;
      link_we     = 1'b0;
      link_waddr  = '0;
      link_wdata  = '0;
      len_we      = 1'b0;
      len_waddr   = '0;
      len_wdata   = '0;

      rover_in    = rover_ff;
      ready_in    = ready_ff;
      brk_in      = brk_ff;
      max_bytes_in = max_bytes_ff;
      min_grow_in = min_grow_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;

      op_in     = op_ff;
      bytes_in  = bytes_ff;
      addr_in   = addr_ff;
      units_in  = units_ff;
      prev_in   = prev_ff;
      p_in      = p_ff;
      nx_in     = nx_ff;
      bp_in     = bp_ff;
      tail_in   = tail_ff;
      plen_in   = plen_ff;
      bplen_in  = bplen_ff;
      bplink_in = bplink_ff;
      asteps_in = asteps_ff;
      psteps_in = psteps_ff;
      grow_in   = grow_ff;
      status_in = status_ff;
      gaddr_in  = gaddr_ff;

      // Configuration writes land whenever offered
      if (csr_we) begin
         unique case (csr_index)
            CSR_MAX_REQUEST: max_bytes_in = csr_wdata;
            CSR_MIN_GROW:    min_grow_in  = csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end

      // Drop the result once taken
      if (rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in    = req_tuser;
               bytes_in = req_tdata[BYTES_W-1:0];
               addr_in  = req_tdata[BYTES_W +: ADDR_W];
            end
         end
         S_START: begin
            status_in = STATUS_OK;
            gaddr_in  = '0;
            units_in  = units_calc;
            asteps_in = '0;
            grow_in   = 1'b0;
            bp_in     = rel_bp;
            if (op_ff == OP_ALLOC) begin
               if (too_large) begin
                  status_in = STATUS_TOO_LARGE;
               end else begin
                  prev_in = ready_ff ? rover_ff : '0;
                  if (!ready_ff) begin
                     // build the sentinel: link 0, length 0
                     link_we  = 1'b1;
                     len_we   = 1'b1;
                     rover_in = '0;
                     ready_in = 1'b1;
                  end
               end
            end
         end
         S_A_HEAD: begin
            raddr = prev_ff;
         end
         S_A_FIRST: begin
            p_in  = lnk_q;
            raddr = lnk_q;
         end
         S_A_EVAL: begin
            priority if (a_fit) begin
               if (a_exact) begin
                  link_we    = 1'b1;
                  link_waddr = prev_ff;
                  link_wdata = lnk_q;
                  rover_in   = prev_ff;
                  gaddr_in   = p_ff + ADDR_W'(1);
               end else if (a_tail_bad) begin
                  status_in = STATUS_NO_MEMORY;
               end else begin
                  // keep the head, hand out the tail
                  len_we    = 1'b1;
                  len_waddr = p_ff;
                  len_wdata = a_rest;
                  tail_in   = a_tail_sum[ADDR_W-1:0];
               end
            end else if (a_at_rover) begin
               if (grow_bad) begin
                  status_in = STATUS_NO_MEMORY;
               end else begin
                  len_we    = 1'b1;
                  len_waddr = brk_ff[ADDR_W-1:0];
                  len_wdata = grow_nu;
                  brk_in    = grow_end[LEN_W-1:0];
                  bp_in     = brk_ff[ADDR_W-1:0];
                  grow_in   = 1'b1;
               end
            end else begin
               asteps_in = asteps_next;
               if (a_over) begin
                  status_in = STATUS_NO_MEMORY;
               end else begin
                  prev_in = p_ff;
                  p_in    = lnk_q;
                  raddr   = lnk_q;
               end
            end
         end
         S_A_SPLIT: begin
            len_we    = 1'b1;
            len_waddr = tail_ff;
            len_wdata = units_ff;
            rover_in  = prev_ff;
            gaddr_in  = tail_ff + ADDR_W'(1);
         end
         S_A_RESUME: begin
            raddr   = rover_ff;
            prev_in = rover_ff;
            p_in    = rover_ff;
         end
         S_A_NEXT: begin
            asteps_in = asteps_next;
            if (a_over) begin
               status_in = STATUS_NO_MEMORY;
            end else begin
               p_in  = lnk_q;
               raddr = lnk_q;
            end
         end
         S_P_START: begin
            raddr     = rover_ff;
            p_in      = rover_ff;
            psteps_in = '0;
         end
         S_P_WALK: begin
            if (p_brk) begin
               nx_in   = lnk_q;
               plen_in = len_q;
               raddr   = bp_ff;
            end else begin
               psteps_in = psteps_next;
               if (p_over) begin
                  // insertion lost: a grow reports no memory, a free is dropped
                  if (grow_ff) status_in = STATUS_NO_MEMORY;
               end else begin
                  p_in  = lnk_q;
                  raddr = lnk_q;
               end
            end
         end
         S_P_BPLEN: begin
            bplen_in = len_q;
            if (bp_merge_nx) begin
               raddr = nx_ff;
            end else begin
               link_we    = 1'b1;
               link_waddr = bp_ff;
               link_wdata = nx_ff;
               bplink_in  = nx_ff;
            end
         end
         S_P_NXRD: begin
            // absorb the upper neighbor
            len_we     = 1'b1;
            len_waddr  = bp_ff;
            len_wdata  = bplen_ff + len_q;
            link_we    = 1'b1;
            link_waddr = bp_ff;
            link_wdata = lnk_q;
            bplen_in   = bplen_ff + len_q;
            bplink_in  = lnk_q;
         end
         S_P_PREV: begin
            link_we    = 1'b1;
            link_waddr = p_ff;
            if (p_merge_bp) begin
               // fold into the lower neighbor
               len_we     = 1'b1;
               len_waddr  = p_ff;
               len_wdata  = plen_ff + bplen_ff;
               link_wdata = bplink_ff;
            end else begin
               link_wdata = bp_ff;
            end
            rover_in = p_ff;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({gaddr_ff, status_ff});
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rover_ff     <= '0;
         ready_ff     <= 1'b0;
         brk_ff       <= LEN_W'(1);
         max_bytes_ff <= MAX_REQUEST_RESET;
         min_grow_ff  <= MIN_GROW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rover_ff     <= rover_in;
         ready_ff     <= ready_in;
         brk_ff       <= brk_in;
         max_bytes_ff <= max_bytes_in;
         min_grow_ff  <= min_grow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      bytes_ff    <= bytes_in;
      addr_ff     <= addr_in;
      units_ff    <= units_in;
      prev_ff     <= prev_in;
      p_ff        <= p_in;
      nx_ff       <= nx_in;
      bp_ff       <= bp_in;
      tail_ff     <= tail_in;
      plen_ff     <= plen_in;
      bplen_ff    <= bplen_in;
      bplink_ff   <= bplink_in;
      asteps_ff   <= asteps_in;
      psteps_ff   <= psteps_in;
      grow_ff     <= grow_in;
      status_ff   <= status_in;
      gaddr_ff    <= gaddr_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for first_fit_heap_allocator_top: predicts every response
// with its own free-list heap model. Depends on ffha_pkg and the allocator RTL only.
module tb;
   import ffha_pkg::*;

   localparam int unsigned WALK_CAP      = 4 * HEAP_UNITS + 8;
   localparam int          SETTLE_CYCLES = 8;
   localparam int          QUIET_LIMIT   = 400000;
   localparam int          TAIL_CYCLES   = 200;

   typedef struct packed {
      status_type              status;
      logic [ADDR_W-1:0]       granted;
   } heap_reply_type;

   // DUT connections; every input starts at a known value
   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;  // request_bytes, block_address, pad
   logic                   req_tuser  = 1'b0; // operation
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;         // status, granted_address
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   // Heap image kept by the predictor
   int unsigned next_free [HEAP_UNITS];
   int unsigned span_units[HEAP_UNITS];
   int unsigned search_start = 0;
   int unsigned break_unit   = 1;
   bit          list_built   = 1'b0;
   int unsigned limit_bytes  = 32'(MAX_REQUEST_RESET);
   int unsigned grow_floor   = 32'(MIN_GROW_RESET);

   heap_reply_type    predicted_grants[$];
   logic [ADDR_W-1:0] live_blocks[$];
   int                error_count    = 0;
   bit                idling_enabled = 1'b1;
   int                receiver_hold  = 0;

   first_fit_heap_allocator_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Link the block with header bp into the address-ordered free list, merging it
   // with free neighbors. Return 0 when the walk runs away (corrupted list).
   function automatic bit link_free_block(input int unsigned bp);
      int unsigned p, nx, steps;
      p     = search_start;
      steps = 0;
      while (1) begin
         nx = next_free[p];
         if (bp > p && bp < nx) break;
         if (p >= nx && (bp > p || bp < nx)) break;
         p = nx;
         steps++;
         if (steps > WALK_CAP) return 1'b0;
      end
      nx = next_free[p];
      if (bp + span_units[bp] == nx) begin
         span_units[bp] += span_units[nx];
         next_free[bp]   = next_free[nx];
      end else begin
         next_free[bp] = nx;
      end
      if (p + span_units[p] == bp) begin
         span_units[p] += span_units[bp];
         next_free[p]   = next_free[bp];
      end else begin
         next_free[p] = bp;
      end
      search_start = p;
      return 1'b1;
   endfunction

   // Advance the heap image by one request and return the response it earns.
   function automatic void predict_heap_response(input logic op,
         input logic [BYTES_W-1:0] bytes, input logic [ADDR_W-1:0] addr,
         output status_type status, output logic [ADDR_W-1:0] granted);
      int unsigned nb, units, prev, p, steps, nu, rest, bp;
      status  = STATUS_OK;
      granted = '0;
      if (op == OP_FREE) begin
         // Drop frees before the list exists, of the sentinel, or past the break
         if (list_built && addr >= 2) begin
            bp = 32'(addr) - 1;
            if (bp < break_unit) void'(link_free_block(bp));
         end
         return;
      end
      nb = 32'(bytes);
      if (nb > limit_bytes) begin
         status = STATUS_TOO_LARGE;
         return;
      end
      units = (nb + UNIT_BYTES - 1) / UNIT_BYTES + 1;
      if (!list_built) begin
         next_free[0]  = 0;
         span_units[0] = 0;
         search_start  = 0;
         list_built    = 1'b1;
      end
      prev  = search_start;
      p     = next_free[prev];
      steps = 0;
      while (1) begin
         if (span_units[p] >= units) begin
            if (span_units[p] == units) begin
               next_free[prev] = next_free[p];
            end else begin
               rest = span_units[p] - units;
               if (p + rest >= HEAP_UNITS) begin
                  status = STATUS_NO_MEMORY;
                  return;
               end
               span_units[p] = rest;
               p             = p + rest;
               span_units[p] = units;
            end
            search_start = prev;
            granted      = ADDR_W'(p + 1);
            return;
         end
         if (p == search_start) begin
            // No fit anywhere: take fresh units from the break
            nu = (units < grow_floor) ? grow_floor : units;
            if (break_unit + nu > HEAP_UNITS) begin
               status = STATUS_NO_MEMORY;
               return;
            end
            bp             = break_unit;
            span_units[bp] = nu;
            break_unit    += nu;
            if (!link_free_block(bp)) begin
               status = STATUS_NO_MEMORY;
               return;
            end
            p = search_start;
         end
         prev = p;
         p    = next_free[p];
         steps++;
         if (steps > WALK_CAP) begin
            status = STATUS_NO_MEMORY;
            return;
         end
      end
   endfunction

   // Offer one request; return once the block has taken the transaction.
   task automatic send_request(input logic op, input logic [BYTES_W-1:0] bytes,
         input logic [ADDR_W-1:0] addr);
      heap_reply_type reply;
      status_type  st;
      logic [ADDR_W-1:0] g;
      if (idling_enabled && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      predict_heap_response(op, bytes, addr, st, g);
      reply.status  = st;
      reply.granted = g;
      predicted_grants.push_back(reply);
      // Track granted blocks so later frees hit real headers only
      if (op == OP_ALLOC && st == STATUS_OK && g != 0) live_blocks.push_back(g);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W - BYTES_W - ADDR_W){1'b0}}, addr, bytes};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Hold the sender off until every predicted response has come back.
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (predicted_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
         input int unsigned value);
      quiesce();
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_MAX_REQUEST) limit_bytes = value & 32'hFFFF;
      else                          grow_floor  = value & 32'h7FFF;
   endtask

   task automatic free_live(input int unsigned pick);
      logic [ADDR_W-1:0] addr;
      addr = live_blocks[pick];
      live_blocks.delete(pick);
      send_request(OP_FREE, BYTES_W'($urandom_range(0, 65535)), addr);
   endtask

   // Frees before the list exists, the ignored addresses, the first growth,
   // a split, and a free that merges on both sides.
   task automatic test_first_requests();
      send_request(OP_FREE, 16'd0, 14'd5);
      send_request(OP_ALLOC, 16'd10241, 14'd0);
      send_request(OP_ALLOC, 16'd0, 14'd0);
      send_request(OP_ALLOC, 16'd10240, 14'd0);
      free_live(0);
      free_live(0);
      send_request(OP_FREE, 16'hFFFF, 14'd0);
      send_request(OP_FREE, 16'd0, 14'd1);
      send_request(OP_FREE, 16'd0, 14'h3FFF);
   endtask

   // Growth at both register extremes, an exact fit, and a block whose header
   // is the last unit of the store (granted address wraps to zero).
   task automatic test_growth_limits();
      write_register(CSR_MAX_REQUEST, 65535);
      write_register(CSR_MIN_GROW, HEAP_UNITS);
      send_request(OP_ALLOC, 16'hFFFF, 14'h3FFF);
      write_register(CSR_MIN_GROW, 1);
      send_request(OP_ALLOC, 16'd16384, 14'd0);
      send_request(OP_ALLOC, 16'd16368, 14'd0);
      write_register(CSR_MAX_REQUEST, 0);
      // Size the next growth so it ends exactly at the top of the store
      write_register(CSR_MIN_GROW, HEAP_UNITS - break_unit);
      send_request(OP_ALLOC, 16'd1, 14'd0);
      send_request(OP_ALLOC, 16'd0, 14'd0);
      free_live(0);
      free_live(0);
   endtask

   // Random allocate/free churn under one register setting.
   task automatic test_random_churn(input int unsigned count, input int unsigned max_bytes,
         input int unsigned grow_units);
      int unsigned done, roll, size_class;
      logic [BYTES_W-1:0] bytes;
      write_register(CSR_MAX_REQUEST, max_bytes);
      write_register(CSR_MIN_GROW, grow_units);
      done = 0;
      while (done < count) begin
         if (done % 50 == 0) idling_enabled = ($urandom_range(0, 3) != 0);
         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            // Noise: frees of the sentinel addresses are ignored
            send_request(OP_FREE, BYTES_W'($urandom_range(0, 65535)),
                         ADDR_W'($urandom_range(0, 1)));
            continue;
         end
         if (live_blocks.size() > 0 && (roll < 48 || live_blocks.size() > 48)) begin
            free_live($urandom_range(0, live_blocks.size() - 1));
         end else begin
            size_class = $urandom_range(0, 99);
            if (size_class < 60)      bytes = BYTES_W'($urandom_range(0, 255));
            else if (size_class < 88) bytes = BYTES_W'($urandom_range(256, 2047));
            else if (size_class < 97) bytes = BYTES_W'($urandom_range(2048, 16383));
            else                      bytes = BYTES_W'($urandom_range(0, 65535));
            send_request(OP_ALLOC, bytes, ADDR_W'($urandom_range(0, HEAP_UNITS - 1)));
         end
         done++;
      end
   endtask

   // Receiver holds off for a long stretch while requests keep coming, so
   // the block backs up into its input; then the sender waits for all results.
   task automatic test_output_stall();
      int unsigned k;
      idling_enabled = 1'b0;
      receiver_hold  = 300;
      for (k = 0; k < 14; k++) begin
         if (k % 3 == 2 && live_blocks.size() > 0) free_live(0);
         else send_request(OP_ALLOC, BYTES_W'(48 * k), 14'd0);
      end
      quiesce();
   endtask

   // Release everything, then free blocks twice: once where the walk runs
   // away and the free is dropped, once where it links an overlapping block.
   task automatic test_unchecked_frees();
      logic [ADDR_W-1:0] upper, middle;
      idling_enabled = 1'b0;
      while (live_blocks.size() != 0) free_live($urandom_range(0, live_blocks.size() - 1));
      repeat (3) send_request(OP_ALLOC, 16'd32, 14'd0);
      if (live_blocks.size() == 3) begin
         upper  = live_blocks[0];
         middle = live_blocks[1];
         send_request(OP_FREE, 16'd0, middle);
         send_request(OP_FREE, 16'd0, middle);
         send_request(OP_FREE, 16'd0, upper);
         send_request(OP_FREE, 16'd0, upper);
         live_blocks.delete(1);
         live_blocks.delete(0);
      end
      send_request(OP_ALLOC, 16'd0, 14'd0);
      send_request(OP_ALLOC, 16'd100, 14'd0);
   endtask

   // Response side: check each transaction against the oldest prediction and
   // drive tready, with random stall bursts and the long hold-off on request.
   initial begin : response_checker
      heap_reply_type want;
      int          hold_left;
      int          burst_left;
      hold_left  = 0;
      burst_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (predicted_grants.size() == 0) begin
               $error("unexpected response: status %0d, granted_address %0d",
                      rsp_tdata[1:0], rsp_tdata[2 +: ADDR_W]);
               error_count++;
            end else begin
               want = predicted_grants.pop_front();
               if (rsp_tdata[1:0] !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tdata[1:0]);
                  error_count++;
               end
               if (rsp_tdata[2 +: ADDR_W] !== want.granted) begin
                  $error("granted_address: expected %0d, actual %0d",
                         want.granted, rsp_tdata[2 +: ADDR_W]);
                  error_count++;
               end
            end
         end
         if (receiver_hold > 0) begin
            hold_left     = receiver_hold;
            receiver_hold = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (burst_left > 0) begin
            burst_left--;
            rsp_tready <= 1'b0;
         end else if (idling_enabled && $urandom_range(0, 4) == 0) begin
            burst_left = $urandom_range(1, 3) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Abort when no transaction moves on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("tb: FAIL");
      $finish;
   end

   initial begin : run_tests
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_first_requests();
      test_growth_limits();
      test_random_churn(380, 65535, 1);
      test_random_churn(380, $urandom_range(1000, 20000), $urandom_range(1, HEAP_UNITS));
      test_random_churn(320, MAX_REQUEST_RESET, MIN_GROW_RESET);
      test_output_stall();
      test_unchecked_frees();
      // Drain, then give a stray response time to show up
      req_tvalid <= 1'b0;
      while (predicted_grants.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && predicted_grants.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

/* first_fit_heap_allocator_top.f */
sv/ffha_pkg.sv
sv/first_fit_heap_allocator_top.sv
tb/sv/tb.sv
